// File: design/tclr_pkg.sv
package tclr_pkg;

    // Default sizes of the text store
    localparam int RING_DEPTH_DEF = 64;
    localparam int LINE_MAX_DEF   = 128;

    // Character codes with a meaning of their own
    localparam logic [7:0] CH_NEWLINE = 8'd10;
    localparam logic [7:0] CH_TAB     = 8'd9;
    localparam logic [7:0] CH_SPACE   = 8'd32;
    localparam logic [7:0] CH_NUL     = 8'd0;

    // Item modes
    localparam logic [1:0] MODE_CHAR   = 2'd0;
    localparam logic [1:0] MODE_SCROLL = 2'd1;
    localparam logic [1:0] MODE_CLEAR  = 2'd2;
    localparam logic [1:0] MODE_READ   = 2'd3;

    // Register indexes
    localparam logic [2:0] REG_LINE_LENGTH = 3'd0;
    localparam logic [2:0] REG_RING_LINES  = 3'd1;
    localparam logic [2:0] REG_VIEW_HEIGHT = 3'd2;
    localparam logic [2:0] REG_TAB_WIDTH   = 3'd3;
    localparam logic [2:0] REG_STOP_FULL   = 3'd4;
    localparam logic [2:0] REG_ONE_LINE    = 3'd5;
    localparam logic [2:0] REG_ENABLE      = 3'd6;

    // Register reset values
    localparam logic [7:0] RST_LINE_LENGTH = 8'd40;
    localparam logic [6:0] RST_RING_LINES  = 7'd64;
    localparam logic [6:0] RST_VIEW_HEIGHT = 7'd20;
    localparam logic [7:0] RST_TAB_WIDTH   = 8'd8;

    // Datapath operations
    localparam logic [4:0] OP_NONE     = 5'd0;
    localparam logic [4:0] OP_LOAD     = 5'd1;
    localparam logic [4:0] OP_FULLDROP = 5'd2;
    localparam logic [4:0] OP_LEAD1    = 5'd3;
    localparam logic [4:0] OP_LEAD2    = 5'd4;
    localparam logic [4:0] OP_LEADPAD  = 5'd5;
    localparam logic [4:0] OP_NEWLINE  = 5'd6;
    localparam logic [4:0] OP_TAB      = 5'd7;
    localparam logic [4:0] OP_CHAR     = 5'd8;
    localparam logic [4:0] OP_WRAP     = 5'd9;
    localparam logic [4:0] OP_TERM     = 5'd10;
    localparam logic [4:0] OP_MODTAB   = 5'd11;
    localparam logic [4:0] OP_MODSCR   = 5'd12;
    localparam logic [4:0] OP_MODSTEP  = 5'd13;
    localparam logic [4:0] OP_SCRPREP  = 5'd14;
    localparam logic [4:0] OP_SCRSET   = 5'd15;
    localparam logic [4:0] OP_CLEAR    = 5'd16;
    localparam logic [4:0] OP_READ     = 5'd17;
    localparam logic [4:0] OP_FINISH   = 5'd18;

    // Effective configuration after clamping
    typedef struct packed {
        logic [7:0] line_len;
        logic [6:0] ring_n;
        logic [6:0] height;
        logic [7:0] tab_w;
        logic       stop_full;
        logic       one_line;
        logic       enable;
    } t_cfg;

    typedef struct packed {
        logic [4:0] op;
    } t_cmd;

    typedef struct packed {
        logic [1:0] mode;
        logic       enable;
        logic       drop;
        logic       full;
        logic       is_lead;
        logic       lead_fits;
        logic       is_nl;
        logic       is_tab;
        logic       is_zero;
        logic       col_ge_ll;
        logic       tab_last;
        logic       retry;
        logic       mod_done;
        logic       out_busy;
    } t_sts;

    // Next line of the ring, wrapping at the ring size
    function automatic logic [6:0] next_line(input logic [6:0] i, input logic [6:0] n);
        logic [7:0] s;
        s = {1'b0, i} + 8'd1;
        return (s >= {1'b0, n}) ? 7'd0 : s[6:0];
    endfunction

    // Signed ring distance from a to b
    function automatic logic signed [8:0] ring_dist(input logic [6:0] a, input logic [6:0] b,
                                                    input logic [6:0] n);
        logic signed [8:0] d;
        d = $signed({2'b0, b}) - $signed({2'b0, a});
        if (b < a) begin
            d = d + $signed({2'b0, n});
        end
        return d;
    endfunction

endpackage

// File: design/tclr_ram.sv
module tclr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = tclr_pkg::RING_DEPTH_DEF * 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: design/tclr_regs.sv
module tclr_regs #(
    parameter int RING_DEPTH = tclr_pkg::RING_DEPTH_DEF,
    parameter int LINE_MAX   = tclr_pkg::LINE_MAX_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [4:0]       paddr,
    input  logic [31:0]      pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    output tclr_pkg::t_cfg   o_cfg
);

    localparam logic [6:0] RING_CAP = (RING_DEPTH > 127) ? 7'd127 : 7'(RING_DEPTH);
    localparam logic [7:0] LEN_CAP  = 8'(LINE_MAX);

    logic [7:0] r_line_length;
    logic [6:0] r_ring_lines;
    logic [6:0] r_view_height;
    logic [7:0] r_tab_width;
    logic       r_stop_full;
    logic       r_one_line;
    logic       r_enable;
    logic [2:0] reg_idx;
    logic       wr_en;
    logic [6:0] ring_n;

    assign reg_idx = paddr[4:2];
    assign wr_en   = psel & penable & pwrite;
    assign pready  = 1'b1;

    // Register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_length <= tclr_pkg::RST_LINE_LENGTH;
            r_ring_lines  <= tclr_pkg::RST_RING_LINES;
            r_view_height <= tclr_pkg::RST_VIEW_HEIGHT;
            r_tab_width   <= tclr_pkg::RST_TAB_WIDTH;
            r_stop_full   <= 1'b0;
            r_one_line    <= 1'b0;
            r_enable      <= 1'b1;
        end else if (wr_en) begin
            unique case (reg_idx)
                tclr_pkg::REG_LINE_LENGTH: r_line_length <= pwdata[7:0];
                tclr_pkg::REG_RING_LINES:  r_ring_lines  <= pwdata[6:0];
                tclr_pkg::REG_VIEW_HEIGHT: r_view_height <= pwdata[6:0];
                tclr_pkg::REG_TAB_WIDTH:   r_tab_width   <= pwdata[7:0];
                tclr_pkg::REG_STOP_FULL:   r_stop_full   <= pwdata[0];
                tclr_pkg::REG_ONE_LINE:    r_one_line    <= pwdata[0];
                tclr_pkg::REG_ENABLE:      r_enable      <= pwdata[0];
                default: ;
            endcase
        end
    end

    // Read back
    always_comb begin
        unique case (reg_idx)
            tclr_pkg::REG_LINE_LENGTH: prdata = {24'd0, r_line_length};
            tclr_pkg::REG_RING_LINES:  prdata = {25'd0, r_ring_lines};
            tclr_pkg::REG_VIEW_HEIGHT: prdata = {25'd0, r_view_height};
            tclr_pkg::REG_TAB_WIDTH:   prdata = {24'd0, r_tab_width};
            tclr_pkg::REG_STOP_FULL:   prdata = {31'd0, r_stop_full};
            tclr_pkg::REG_ONE_LINE:    prdata = {31'd0, r_one_line};
            tclr_pkg::REG_ENABLE:      prdata = {31'd0, r_enable};
            default:                   prdata = 32'd0;
        endcase
    end

    // Clamp the raw values to the working ranges
    always_comb begin
        if (r_ring_lines < 7'd2) begin
            ring_n = 7'd2;
        end else if (r_ring_lines > RING_CAP) begin
            ring_n = RING_CAP;
        end else begin
            ring_n = r_ring_lines;
        end
        o_cfg.ring_n = ring_n;
        o_cfg.height = (r_view_height > ring_n) ? ring_n : r_view_height;
        if (r_line_length == 8'd0) begin
            o_cfg.line_len = 8'd1;
        end else if (r_line_length > LEN_CAP) begin
            o_cfg.line_len = LEN_CAP;
        end else begin
            o_cfg.line_len = r_line_length;
        end
        o_cfg.tab_w     = (r_tab_width == 8'd0) ? 8'd1 : r_tab_width;
        o_cfg.stop_full = r_stop_full;
        o_cfg.one_line  = r_one_line;
        o_cfg.enable    = r_enable;
    end

endmodule

// File: design/tclr_ctrl.sv
module tclr_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  tclr_pkg::t_sts i_sts,
    output tclr_pkg::t_cmd o_cmd
);

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_DISPATCH = 4'd1;
    localparam logic [3:0] S_PASS     = 4'd2;
    localparam logic [3:0] S_TRAIL    = 4'd3;
    localparam logic [3:0] S_TABMOD   = 4'd4;
    localparam logic [3:0] S_TAB      = 4'd5;
    localparam logic [3:0] S_WRAPCHK  = 4'd6;
    localparam logic [3:0] S_WRAPZ    = 4'd7;
    localparam logic [3:0] S_TERM     = 4'd8;
    localparam logic [3:0] S_SCROLL   = 4'd9;
    localparam logic [3:0] S_SCRSEL   = 4'd10;
    localparam logic [3:0] S_SCRMOD   = 4'd11;
    localparam logic [3:0] S_CLEAR    = 4'd12;
    localparam logic [3:0] S_READ     = 4'd13;
    localparam logic [3:0] S_FINISH   = 4'd14;

    logic [3:0] r_state;
    logic [3:0] n_state;
    logic       r_pass;
    logic       n_pass;
    logic       again;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_pass  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pass  <= n_pass;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

    // A lead byte that did not fit is tried once more on the fresh line
    assign again = i_sts.retry & ~i_sts.drop & ~r_pass;

    always_comb begin
        n_state  = r_state;
        n_pass   = r_pass;
        o_cmd.op = tclr_pkg::OP_NONE;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.op = tclr_pkg::OP_LOAD;
                    n_state  = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                unique case (i_sts.mode)
                    tclr_pkg::MODE_CHAR: begin
                        n_pass  = 1'b0;
                        n_state = (i_sts.enable && !i_sts.drop) ? S_PASS : S_FINISH;
                    end
                    tclr_pkg::MODE_SCROLL: n_state = S_SCROLL;
                    tclr_pkg::MODE_CLEAR:  n_state = S_CLEAR;
                    default:               n_state = S_READ;
                endcase
            end
            S_PASS: begin
                if (i_sts.full) begin
                    o_cmd.op = tclr_pkg::OP_FULLDROP;
                    n_state  = S_TERM;
                end else if (i_sts.is_lead) begin
                    if (i_sts.lead_fits) begin
                        o_cmd.op = tclr_pkg::OP_LEAD1;
                        n_state  = S_TRAIL;
                    end else begin
                        o_cmd.op = tclr_pkg::OP_LEADPAD;
                        n_state  = S_WRAPCHK;
                    end
                end else if (i_sts.is_nl) begin
                    o_cmd.op = tclr_pkg::OP_NEWLINE;
                    n_state  = S_WRAPCHK;
                end else if (i_sts.is_tab) begin
                    o_cmd.op = tclr_pkg::OP_MODTAB;
                    n_state  = S_TABMOD;
                end else if (i_sts.is_zero) begin
                    n_state = S_WRAPCHK;
                end else begin
                    o_cmd.op = tclr_pkg::OP_CHAR;
                    n_state  = S_WRAPCHK;
                end
            end
            S_TRAIL: begin
                o_cmd.op = tclr_pkg::OP_LEAD2;
                n_state  = S_WRAPCHK;
            end
            S_TABMOD: begin
                if (i_sts.mod_done) begin
                    n_state = S_TAB;
                end else begin
                    o_cmd.op = tclr_pkg::OP_MODSTEP;
                end
            end
            S_TAB: begin
                if (i_sts.col_ge_ll) begin
                    n_state = S_WRAPCHK;
                end else begin
                    o_cmd.op = tclr_pkg::OP_TAB;
                    if (i_sts.tab_last) begin
                        n_state = S_WRAPCHK;
                    end
                end
            end
            S_WRAPCHK: begin
                if (i_sts.col_ge_ll) begin
                    o_cmd.op = tclr_pkg::OP_WRAP;
                    n_state  = S_WRAPZ;
                end else if (again) begin
                    n_pass  = 1'b1;
                    n_state = S_PASS;
                end else begin
                    n_state = S_TERM;
                end
            end
            S_WRAPZ: begin
                // Column is zero here: this clears the fresh line's first byte
                o_cmd.op = tclr_pkg::OP_TERM;
                if (again) begin
                    n_pass  = 1'b1;
                    n_state = S_PASS;
                end else begin
                    n_state = S_FINISH;
                end
            end
            S_TERM: begin
                o_cmd.op = tclr_pkg::OP_TERM;
                n_state  = S_FINISH;
            end
            S_SCROLL: begin
                o_cmd.op = tclr_pkg::OP_SCRPREP;
                n_state  = S_SCRSEL;
            end
            S_SCRSEL: begin
                o_cmd.op = tclr_pkg::OP_MODSCR;
                n_state  = S_SCRMOD;
            end
            S_SCRMOD: begin
                if (i_sts.mod_done) begin
                    o_cmd.op = tclr_pkg::OP_SCRSET;
                    n_state  = S_FINISH;
                end else begin
                    o_cmd.op = tclr_pkg::OP_MODSTEP;
                end
            end
            S_CLEAR: begin
                o_cmd.op = tclr_pkg::OP_CLEAR;
                n_state  = S_FINISH;
            end
            S_READ: begin
                o_cmd.op = tclr_pkg::OP_READ;
                n_state  = S_FINISH;
            end
            S_FINISH: begin
                if (!i_sts.out_busy) begin
                    o_cmd.op = tclr_pkg::OP_FINISH;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

// File: design/tclr_dp.sv
module tclr_dp #(
    parameter int RING_DEPTH = tclr_pkg::RING_DEPTH_DEF,
    parameter int LINE_MAX   = tclr_pkg::LINE_MAX_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  tclr_pkg::t_cfg i_cfg,
    input  tclr_pkg::t_cmd i_cmd,
    output tclr_pkg::t_sts o_sts,
    input  logic [1:0]     i_mode,
    input  logic [7:0]     i_char_code,
    input  logic [7:0]     i_trail_code,
    input  logic           i_is_lead,
    input  logic           i_last_of_string,
    input  logic [7:0]     i_scroll_amount,
    input  logic [5:0]     i_read_line,
    input  logic [7:0]     i_read_column,
    input  logic           i_out_ready,
    output logic           o_out_valid,
    output logic [7:0]     o_read_byte,
    output logic           o_line_in_use,
    output logic [5:0]     o_write_line,
    output logic [7:0]     o_column,
    output logic [5:0]     o_top_line,
    output logic [5:0]     o_oldest_line,
    output logic [5:0]     o_used_lines,
    output logic [5:0]     o_line_offset,
    output logic           o_discarding
);

    localparam int LW        = $clog2(RING_DEPTH);
    localparam int CW        = $clog2(LINE_MAX + 1);
    localparam int MEM_DEPTH = RING_DEPTH * (2 ** CW);

    // Latched item
    logic [1:0] r_mode;
    logic [7:0] r_char;
    logic [7:0] r_trail;
    logic       r_lead;
    logic       r_last;
    logic [7:0] r_scroll;
    logic [5:0] r_rline;
    logic [7:0] r_rcol;

    // Console state
    logic [6:0]            r_wi, n_wi;
    logic [7:0]            r_col, n_col;
    logic [6:0]            r_top, n_top;
    logic [6:0]            r_old, n_old;
    logic                  r_drop, n_drop;
    logic [RING_DEPTH-1:0] r_used, n_used;
    logic                  r_retry, n_retry;

    // Remainder unit, one quotient bit per cycle
    logic [7:0]        r_mod_rem, n_mod_rem;
    logic [7:0]        r_mod_num, n_mod_num;
    logic [7:0]        r_mod_den, n_mod_den;
    logic [3:0]        r_mod_cnt, n_mod_cnt;
    logic signed [9:0] r_scr_v, n_scr_v;

    // Result register
    logic       r_out_valid;
    logic [7:0] r_out_byte;
    logic       r_out_inuse;
    logic [5:0] r_out_wi;
    logic [7:0] r_out_col;
    logic [5:0] r_out_top;
    logic [5:0] r_out_old;
    logic [5:0] r_out_used;
    logic [5:0] r_out_ofs;
    logic       r_out_drop;

    // Store port
    logic             mem_we;
    logic [6:0]       mem_wline;
    logic [7:0]       mem_wcol;
    logic [7:0]       mem_wdata;
    logic [LW+CW-1:0] mem_waddr;
    logic [LW+CW-1:0] mem_raddr;
    logic [7:0]       mem_rdata;
    logic             mem_re;

    // Helpers
    logic [8:0]        tmp9;
    logic [6:0]        wnew;
    logic [6:0]        top1;
    logic signed [9:0] sv;
    logic signed [9:0] dlim;
    logic signed [8:0] d_ot;
    logic signed [8:0] d_ow;
    logic signed [8:0] d_tw;
    logic signed [8:0] d_tn;
    logic signed [8:0] h_s;
    logic signed [9:0] vneg;
    logic              read_ok;
    logic              out_take;

    assign h_s      = $signed({2'b0, i_cfg.height});
    assign d_ot     = tclr_pkg::ring_dist(r_old, r_top, i_cfg.ring_n);
    assign d_ow     = tclr_pkg::ring_dist(r_old, r_wi, i_cfg.ring_n);
    assign d_tw     = tclr_pkg::ring_dist(r_top, r_wi, i_cfg.ring_n);
    assign read_ok  = (int'(r_rline) < RING_DEPTH) && (r_rcol <= 8'(LINE_MAX));
    assign out_take = r_out_valid & i_out_ready;
    assign vneg     = -r_scr_v;

    tclr_ram #(
        .WIDTH (8),
        .DEPTH (MEM_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    assign mem_waddr = {LW'(mem_wline), CW'(mem_wcol)};
    assign mem_raddr = {LW'(r_rline), CW'(r_rcol)};
    assign mem_re    = (i_cmd.op == tclr_pkg::OP_READ);

    // Status towards the controller
    always_comb begin
        o_sts.mode      = r_mode;
        o_sts.enable    = i_cfg.enable;
        o_sts.drop      = r_drop;
        o_sts.full      = i_cfg.stop_full &&
                          (r_old == tclr_pkg::next_line(r_wi, i_cfg.ring_n));
        o_sts.is_lead   = r_lead;
        o_sts.lead_fits = ({1'b0, r_col} + 9'd1) < {1'b0, i_cfg.line_len};
        o_sts.is_nl     = (r_char == tclr_pkg::CH_NEWLINE);
        o_sts.is_tab    = (r_char == tclr_pkg::CH_TAB);
        o_sts.is_zero   = (r_char == tclr_pkg::CH_NUL);
        o_sts.col_ge_ll = (r_col >= i_cfg.line_len);
        o_sts.tab_last  = (({1'b0, r_col} + 9'd1) >= {1'b0, i_cfg.line_len}) ||
                          (({1'b0, r_mod_rem} + 9'd1) == {1'b0, i_cfg.tab_w});
        o_sts.retry     = r_retry;
        o_sts.mod_done  = (r_mod_cnt == 4'd8);
        o_sts.out_busy  = r_out_valid & ~i_out_ready;
    end

    // Operation decode
    always_comb begin
        n_wi      = r_wi;
        n_col     = r_col;
        n_top     = r_top;
        n_old     = r_old;
        n_drop    = r_drop;
        n_used    = r_used;
        n_retry   = r_retry;
        n_mod_rem = r_mod_rem;
        n_mod_num = r_mod_num;
        n_mod_den = r_mod_den;
        n_mod_cnt = r_mod_cnt;
        n_scr_v   = r_scr_v;
        mem_we    = 1'b0;
        mem_wline = r_wi;
        mem_wcol  = r_col;
        mem_wdata = tclr_pkg::CH_NUL;
        tmp9      = 9'd0;
        wnew      = r_wi;
        top1      = r_top;
        sv        = 10'sd0;
        dlim      = 10'sd0;
        d_tn      = 9'sd0;
        case (i_cmd.op)
            tclr_pkg::OP_LOAD: begin
                n_retry = 1'b0;
            end
            tclr_pkg::OP_FULLDROP: begin
                n_drop = 1'b1;
            end
            tclr_pkg::OP_LEAD1: begin
                mem_we    = 1'b1;
                mem_wdata = r_char;
            end
            tclr_pkg::OP_LEAD2: begin
                mem_we    = 1'b1;
                mem_wcol  = r_col + 8'd1;
                mem_wdata = r_trail;
                n_col     = r_col + 8'd2;
            end
            tclr_pkg::OP_LEADPAD: begin
                mem_we  = 1'b1;
                n_col   = r_col + 8'd1;
                n_retry = (r_col != 8'd0);
            end
            tclr_pkg::OP_NEWLINE: begin
                n_col = i_cfg.line_len;
            end
            tclr_pkg::OP_TAB: begin
                mem_we    = 1'b1;
                mem_wdata = tclr_pkg::CH_SPACE;
                n_col     = r_col + 8'd1;
                n_mod_rem = r_mod_rem + 8'd1;
            end
            tclr_pkg::OP_CHAR: begin
                mem_we    = 1'b1;
                mem_wdata = r_char;
                n_col     = r_col + 8'd1;
            end
            tclr_pkg::OP_WRAP: begin
                // Terminate the old line, then push view top and oldest line
                mem_we = 1'b1;
                wnew   = tclr_pkg::next_line(r_wi, i_cfg.ring_n);
                n_wi   = wnew;
                n_col  = 8'd0;
                n_used[LW'(wnew)] = 1'b1;
                d_tn   = tclr_pkg::ring_dist(r_top, wnew, i_cfg.ring_n);
                top1   = (d_tn == h_s) ? tclr_pkg::next_line(r_top, i_cfg.ring_n) : r_top;
                if (wnew == r_old) begin
                    n_old = tclr_pkg::next_line(r_old, i_cfg.ring_n);
                end
                n_top  = (wnew == top1) ? tclr_pkg::next_line(top1, i_cfg.ring_n) : top1;
                if (i_cfg.one_line) begin
                    n_drop = 1'b1;
                end
            end
            tclr_pkg::OP_TERM: begin
                mem_we = 1'b1;
            end
            tclr_pkg::OP_MODTAB: begin
                n_mod_num = r_col;
                n_mod_den = i_cfg.tab_w;
                n_mod_rem = 8'd0;
                n_mod_cnt = 4'd0;
            end
            tclr_pkg::OP_MODSCR: begin
                n_mod_num = r_scr_v[9] ? vneg[7:0] : r_scr_v[7:0];
                n_mod_den = {1'b0, i_cfg.ring_n};
                n_mod_rem = 8'd0;
                n_mod_cnt = 4'd0;
            end
            tclr_pkg::OP_MODSTEP: begin
                tmp9 = {r_mod_rem, r_mod_num[7]};
                if (tmp9 >= {1'b0, r_mod_den}) begin
                    tmp9 = tmp9 - {1'b0, r_mod_den};
                end
                n_mod_rem = tmp9[7:0];
                n_mod_num = {r_mod_num[6:0], 1'b0};
                n_mod_cnt = r_mod_cnt + 4'd1;
            end
            tclr_pkg::OP_SCRPREP: begin
                // Clamp the move against the oldest line and the write line
                sv = 10'(signed'(r_scroll));
                if (sv < 10'sd0) begin
                    if (sv < -10'(d_ot)) begin
                        sv = -10'(d_ot);
                    end
                end else if (sv > 10'sd0) begin
                    if ((d_ow + 9'sd1) <= h_s) begin
                        sv = 10'sd0;
                    end else begin
                        dlim = 10'(d_tw) - 10'(h_s) + 10'sd1;
                        if (sv > dlim) begin
                            sv = dlim;
                        end
                    end
                end
                n_scr_v = $signed({3'b0, r_top}) + sv;
            end
            tclr_pkg::OP_SCRSET: begin
                if (r_scr_v[9] && (r_mod_rem != 8'd0)) begin
                    n_top = i_cfg.ring_n - r_mod_rem[6:0];
                end else begin
                    n_top = r_mod_rem[6:0];
                end
            end
            tclr_pkg::OP_CLEAR: begin
                n_wi      = 7'd0;
                n_col     = 8'd0;
                n_top     = 7'd0;
                n_old     = 7'd0;
                n_drop    = 1'b0;
                n_used    = RING_DEPTH'(1);
                mem_we    = 1'b1;
                mem_wline = 7'd0;
                mem_wcol  = 8'd0;
            end
            tclr_pkg::OP_FINISH: begin
                if ((r_mode == tclr_pkg::MODE_CHAR) && r_last) begin
                    n_drop = 1'b0;
                end
            end
            default: ;
        endcase
    end

    // Item latch
    always_ff @(posedge i_clk) begin
        if (i_cmd.op == tclr_pkg::OP_LOAD) begin
            r_mode   <= i_mode;
            r_char   <= i_char_code;
            r_trail  <= i_trail_code;
            r_lead   <= i_is_lead;
            r_last   <= i_last_of_string;
            r_scroll <= i_scroll_amount;
            r_rline  <= i_read_line;
            r_rcol   <= i_read_column;
        end
    end

    // Console state and remainder unit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wi    <= 7'd0;
            r_col   <= 8'd0;
            r_top   <= 7'd0;
            r_old   <= 7'd0;
            r_drop  <= 1'b0;
            r_used  <= RING_DEPTH'(1);
            r_retry <= 1'b0;
        end else begin
            r_wi    <= n_wi;
            r_col   <= n_col;
            r_top   <= n_top;
            r_old   <= n_old;
            r_drop  <= n_drop;
            r_used  <= n_used;
            r_retry <= n_retry;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mod_rem <= n_mod_rem;
        r_mod_num <= n_mod_num;
        r_mod_den <= n_mod_den;
        r_mod_cnt <= n_mod_cnt;
        r_scr_v   <= n_scr_v;
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.op == tclr_pkg::OP_FINISH) begin
            r_out_valid <= 1'b1;
        end else if (out_take) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == tclr_pkg::OP_FINISH) begin
            if ((r_mode == tclr_pkg::MODE_READ) && read_ok) begin
                r_out_byte  <= mem_rdata;
                r_out_inuse <= r_used[LW'(r_rline)];
            end else begin
                r_out_byte  <= 8'd0;
                r_out_inuse <= 1'b0;
            end
            r_out_wi   <= r_wi[5:0];
            r_out_col  <= r_col;
            r_out_top  <= r_top[5:0];
            r_out_old  <= r_old[5:0];
            r_out_used <= d_ow[5:0];
            r_out_ofs  <= d_ot[5:0];
            r_out_drop <= n_drop;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_read_byte   = r_out_byte;
    assign o_line_in_use = r_out_inuse;
    assign o_write_line  = r_out_wi;
    assign o_column      = r_out_col;
    assign o_top_line    = r_out_top;
    assign o_oldest_line = r_out_old;
    assign o_used_lines  = r_out_used;
    assign o_line_offset = r_out_ofs;
    assign o_discarding  = r_out_drop;

endmodule

// File: design/text_console_line_ring_top.sv
// Text console with a ring of fixed-length lines and scrollback. Each input item is a
// character, a scroll, a clear or a read of one stored byte, and gives exactly one result
// item with the read byte and the console indices after the item. Items are handled one at
// a time; the text store has a single write port, so stored bytes are written in turn.
// A lead byte that does not fit may run its pass twice. A tab first finds its column
// within the tab stop and then writes its spaces one at a time (at most tab_width). A
// scroll takes a bit-serial remainder against the ring size. A result that waits on the
// output keeps the next item from finishing until it is taken. The store is not cleared
// after reset; bytes never written are for the user not to read: the block does not enforce it.
module text_console_line_ring_top #(
    parameter int RING_DEPTH = tclr_pkg::RING_DEPTH_DEF,
    parameter int LINE_MAX   = tclr_pkg::LINE_MAX_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input items
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // char_code[7:0], trail_code[15:8], scroll_amount[23:16], read_line[29:24],
    // read_column[37:30], zero fill[39:38]
    input  logic [39:0] s_axis_tdata,
    // mode[1:0], is_lead[2]
    input  logic [2:0]  s_axis_tuser,
    // last_of_string
    input  logic        s_axis_tlast,
    // Result items
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // read_byte[7:0], line_in_use[8], write_line[14:9], column[22:15], top_line[28:23],
    // oldest_line[34:29], used_lines[40:35], line_offset[46:41], discarding[47]
    output logic [47:0] m_axis_tdata,
    // Configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    tclr_pkg::t_cfg cfg;
    tclr_pkg::t_cmd cmd;
    tclr_pkg::t_sts sts;

    tclr_regs #(
        .RING_DEPTH (RING_DEPTH),
        .LINE_MAX   (LINE_MAX)
    ) u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    tclr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    tclr_dp #(
        .RING_DEPTH (RING_DEPTH),
        .LINE_MAX   (LINE_MAX)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg            (cfg),
        .i_cmd            (cmd),
        .o_sts            (sts),
        .i_mode           (s_axis_tuser[1:0]),
        .i_char_code      (s_axis_tdata[7:0]),
        .i_trail_code     (s_axis_tdata[15:8]),
        .i_is_lead        (s_axis_tuser[2]),
        .i_last_of_string (s_axis_tlast),
        .i_scroll_amount  (s_axis_tdata[23:16]),
        .i_read_line      (s_axis_tdata[29:24]),
        .i_read_column    (s_axis_tdata[37:30]),
        .i_out_ready      (m_axis_tready),
        .o_out_valid      (m_axis_tvalid),
        .o_read_byte      (m_axis_tdata[7:0]),
        .o_line_in_use    (m_axis_tdata[8]),
        .o_write_line     (m_axis_tdata[14:9]),
        .o_column         (m_axis_tdata[22:15]),
        .o_top_line       (m_axis_tdata[28:23]),
        .o_oldest_line    (m_axis_tdata[34:29]),
        .o_used_lines     (m_axis_tdata[40:35]),
        .o_line_offset    (m_axis_tdata[46:41]),
        .o_discarding     (m_axis_tdata[47])
    );

endmodule

// File: tb/sv/tb_text_console_line_ring_top.sv
`timescale 1ns / 1ps

module tb_text_console_line_ring_top;

    localparam int DEPTH = tclr_pkg::RING_DEPTH_DEF;
    localparam int LMAX = tclr_pkg::LINE_MAX_DEF;
    localparam int STALL_LIMIT = 20000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata = '0;
    logic [2:0]  s_axis_tuser = '0;
    logic        s_axis_tlast = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [47:0] m_axis_tdata;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [4:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    text_console_line_ring_top DUT (.*);

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Console state as the block should hold it
    logic [7:0] text_lines [DEPTH][LMAX+1];
    bit         byte_known [DEPTH][LMAX+1];
    bit         line_mark [DEPTH];
    int top_ix, oldest_ix, write_ix, write_col;
    bit drop_on;
    int cfg_len, cfg_ring, cfg_height, cfg_tab, cfg_stop, cfg_one, cfg_en;

    logic [47:0] status_queue [$];
    int  failures = 0;
    bit  no_idle = 1'b0;
    int  quiet_cycles = 0;

    function automatic int line_len_eff();
        if (cfg_len == 0) return 1;
        return cfg_len > LMAX ? LMAX : cfg_len;
    endfunction

    function automatic int ring_eff();
        if (cfg_ring < 2) return 2;
        return cfg_ring > DEPTH ? DEPTH : cfg_ring;
    endfunction

    function automatic int height_eff();
        return cfg_height > ring_eff() ? ring_eff() : cfg_height;
    endfunction

    function automatic void store_byte(int ln, int col, logic [7:0] v);
        if (ln >= 0 && ln < DEPTH && col >= 0 && col <= LMAX) begin
            text_lines[ln][col] = v;
            byte_known[ln][col] = 1'b1;
        end
    endfunction

    function automatic int line_after(int i);
        return (i + 1 >= ring_eff()) ? 0 : i + 1;
    endfunction

    function automatic int lines_between(int a, int b);
        return (b >= a) ? b - a : b - a + ring_eff();
    endfunction

    function automatic void advance_line();
        store_byte(write_ix, write_col, tclr_pkg::CH_NUL);
        write_ix = line_after(write_ix);
        write_col = 0;
        line_mark[write_ix] = 1'b1;
        store_byte(write_ix, 0, tclr_pkg::CH_NUL);
        if (lines_between(top_ix, write_ix) == height_eff()) top_ix = line_after(top_ix);
        if (write_ix == oldest_ix) oldest_ix = line_after(oldest_ix);
        if (write_ix == top_ix) top_ix = line_after(top_ix);
        if (cfg_one != 0) drop_on = 1'b1;
    endfunction

    function automatic void place_char(logic [7:0] c, logic [7:0] trail, bit lead);
        int ll;
        int tw;
        int start;
        bit retry;
        ll = line_len_eff();
        tw = (cfg_tab == 0) ? 1 : cfg_tab;
        for (int pass = 0; pass < 2; pass++) begin
            retry = 1'b0;
            start = write_col;
            if (cfg_stop != 0 && oldest_ix == line_after(write_ix)) begin
                drop_on = 1'b1;
                break;
            end
            if (lead) begin
                if (write_col + 1 < ll) begin
                    store_byte(write_ix, write_col, c);
                    store_byte(write_ix, write_col + 1, trail);
                    write_col += 2;
                end else begin
                    store_byte(write_ix, write_col, tclr_pkg::CH_NUL);
                    write_col++;
                    retry = start > 0;
                end
            end else if (c == tclr_pkg::CH_NEWLINE) begin
                write_col = ll;
            end else if (c == tclr_pkg::CH_TAB) begin
                while (write_col < ll) begin
                    store_byte(write_ix, write_col, tclr_pkg::CH_SPACE);
                    write_col++;
                    if (write_col % tw == 0) break;
                end
            end else if (c != tclr_pkg::CH_NUL) begin
                store_byte(write_ix, write_col, c);
                write_col++;
            end
            if (write_col >= ll) advance_line();
            if (!retry || drop_on) break;
        end
        store_byte(write_ix, write_col, tclr_pkg::CH_NUL);
    endfunction

    function automatic void move_view(int s);
        int n;
        int h;
        int t;
        n = ring_eff();
        h = height_eff();
        if (s < 0) begin
            if (s < -lines_between(oldest_ix, top_ix)) s = -lines_between(oldest_ix, top_ix);
        end else if (s > 0) begin
            if (lines_between(oldest_ix, write_ix) + 1 <= h) s = 0;
            else if (s > lines_between(top_ix, write_ix) - h + 1)
                s = lines_between(top_ix, write_ix) - h + 1;
        end
        t = (top_ix + s) % n;
        if (t < 0) t += n;
        top_ix = t;
    endfunction

    function automatic void clear_console();
        top_ix = 0;
        oldest_ix = 0;
        write_ix = 0;
        write_col = 0;
        drop_on = 1'b0;
        foreach (line_mark[i]) line_mark[i] = 1'b0;
        line_mark[0] = 1'b1;
        store_byte(0, 0, tclr_pkg::CH_NUL);
    endfunction

    // Work out the status item that one accepted input item leaves behind
    function automatic logic [47:0] console_status(logic [1:0] mode, logic [7:0] c,
                                                   logic [7:0] trail, bit lead, bit last,
                                                   logic [7:0] scroll, logic [5:0] rline,
                                                   logic [7:0] rcol);
        logic [7:0] rb;
        logic       inuse;
        rb = '0;
        inuse = 1'b0;
        case (mode)
            tclr_pkg::MODE_CHAR: begin
                if (cfg_en != 0 && !drop_on) place_char(c, trail, lead);
                if (last) drop_on = 1'b0;
            end
            tclr_pkg::MODE_SCROLL: move_view($signed(scroll));
            tclr_pkg::MODE_CLEAR: clear_console();
            default: begin
                if (rcol <= LMAX) begin
                    rb = text_lines[rline][rcol];
                    inuse = line_mark[rline];
                end
            end
        endcase
        return {drop_on, 6'(lines_between(oldest_ix, top_ix)),
                6'(lines_between(oldest_ix, write_ix)), 6'(oldest_ix), 6'(top_ix),
                8'(write_col), 6'(write_ix), inuse, rb};
    endfunction

    // Receiver stalls
    always @(posedge i_clk) begin
        m_axis_tready <= no_idle || ($urandom_range(99) >= 23);
    end

    task automatic check_field(string name, int want, int got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            failures++;
        end
    endtask

    // Compare each status item against the oldest prediction
    always @(posedge i_clk) begin
        logic [47:0] want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (status_queue.size() == 0) begin
                $display("%0t: unexpected item, expected none, actual %h", $time, m_axis_tdata);
                failures++;
            end else begin
                want = status_queue.pop_front();
                check_field("read_byte", want[7:0], m_axis_tdata[7:0]);
                check_field("line_in_use", want[8], m_axis_tdata[8]);
                check_field("write_line", want[14:9], m_axis_tdata[14:9]);
                check_field("column", want[22:15], m_axis_tdata[22:15]);
                check_field("top_line", want[28:23], m_axis_tdata[28:23]);
                check_field("oldest_line", want[34:29], m_axis_tdata[34:29]);
                check_field("used_lines", want[40:35], m_axis_tdata[40:35]);
                check_field("line_offset", want[46:41], m_axis_tdata[46:41]);
                check_field("discarding", want[47], m_axis_tdata[47]);
            end
        end
    end

    // Watchdog on cycles with no item moving
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    // Send one item, predicting its status once it is accepted
    task automatic send_item(logic [1:0] mode, logic [7:0] c, logic [7:0] trail, bit lead,
                             bit last, logic [7:0] scroll, logic [5:0] rline,
                             logic [7:0] rcol);
        if (!no_idle && $urandom_range(99) < 23) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(4, 1)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {2'b00, rcol, rline, scroll, trail, c};
        s_axis_tuser <= {lead, mode};
        s_axis_tlast <= last;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        status_queue.insert(status_queue.size(),
                            console_status(mode, c, trail, lead, last, scroll, rline, rcol));
    endtask

    task automatic drain();
        if (s_axis_tvalid) s_axis_tvalid <= 1'b0;
        while (status_queue.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [2:0] idx, int value);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            tclr_pkg::REG_LINE_LENGTH: cfg_len = value & 8'hff;
            tclr_pkg::REG_RING_LINES:  cfg_ring = value & 7'h7f;
            tclr_pkg::REG_VIEW_HEIGHT: cfg_height = value & 7'h7f;
            tclr_pkg::REG_TAB_WIDTH:   cfg_tab = value & 8'hff;
            tclr_pkg::REG_STOP_FULL:   cfg_stop = value & 1;
            tclr_pkg::REG_ONE_LINE:    cfg_one = value & 1;
            tclr_pkg::REG_ENABLE:      cfg_en = value & 1;
            default: ;
        endcase
    endtask

    task automatic configure(int len, int ring, int height, int tab, int stop, int one,
                             int en);
        drain();
        write_reg(tclr_pkg::REG_LINE_LENGTH, len);
        write_reg(tclr_pkg::REG_RING_LINES, ring);
        write_reg(tclr_pkg::REG_VIEW_HEIGHT, height);
        write_reg(tclr_pkg::REG_TAB_WIDTH, tab);
        write_reg(tclr_pkg::REG_STOP_FULL, stop);
        write_reg(tclr_pkg::REG_ONE_LINE, one);
        write_reg(tclr_pkg::REG_ENABLE, en);
    endtask

    task automatic send_char(logic [7:0] c, bit lead, bit last);
        send_item(tclr_pkg::MODE_CHAR, c, 8'($urandom), lead, last, 8'($urandom),
                  6'($urandom), 8'($urandom));
    endtask

    task automatic send_scroll(int amount);
        send_item(tclr_pkg::MODE_SCROLL, 8'($urandom), 8'($urandom), 1'($urandom),
                  1'($urandom), 8'(amount), 6'($urandom), 8'($urandom));
    endtask

    // Read a byte that has been written, or a column past the end of the line
    task automatic send_read();
        int ln;
        int col;
        ln = $urandom_range(DEPTH - 1);
        col = $urandom_range(LMAX);
        for (int k = 0; k < 20 && !byte_known[ln][col]; k++) begin
            ln = $urandom_range(DEPTH - 1);
            col = (k < 10) ? $urandom_range(3) : $urandom_range(LMAX);
        end
        if (!byte_known[ln][col]) col = $urandom_range(255, LMAX + 1);
        send_item(tclr_pkg::MODE_READ, 8'($urandom), 8'($urandom), 1'($urandom),
                  1'($urandom), 8'($urandom), 6'(ln), 8'(col));
    endtask

    task automatic test_directed();
        send_char("A", 1'b0, 1'b0);
        send_char(8'hff, 1'b0, 1'b0);
        send_char(tclr_pkg::CH_NUL, 1'b0, 1'b0);
        send_char(tclr_pkg::CH_TAB, 1'b0, 1'b0);
        send_char(8'h81, 1'b1, 1'b0);
        send_char(tclr_pkg::CH_NEWLINE, 1'b0, 1'b1);
        send_read();
        send_item(tclr_pkg::MODE_READ, '0, '0, 1'b0, 1'b0, '0, 6'd0, 8'd0);
        send_item(tclr_pkg::MODE_READ, '0, '0, 1'b0, 1'b0, '0, 6'd63, 8'd255);
        send_scroll(-64);
        send_scroll(64);
        send_item(tclr_pkg::MODE_CLEAR, '0, '0, 1'b0, 1'b0, '0, '0, '0);
        // Lead bytes that do not fit on a three-column line
        configure(3, 4, 2, 1, 0, 0, 1);
        send_char("x", 1'b0, 1'b0);
        send_char("y", 1'b0, 1'b0);
        send_char(8'h82, 1'b1, 1'b0);
        send_char(8'h83, 1'b1, 1'b1);
        send_char(8'h84, 1'b1, 1'b0);
        // Disabled console ignores text but honors the end of a string
        configure(1, 2, 0, 128, 1, 1, 0);
        send_char("z", 1'b0, 1'b1);
        send_read();
    endtask

    // Strings of random characters, with scrolls, reads, clears and noise between
    task automatic test_random(int count);
        int sent;
        int len;
        int kind;
        logic [7:0] c;
        sent = 0;
        while (sent < count) begin
            kind = $urandom_range(99);
            if (kind < 70) begin
                len = $urandom_range(12, 1);
                for (int k = 0; k < len; k++) begin
                    kind = $urandom_range(99);
                    if (kind < 10) c = tclr_pkg::CH_NEWLINE;
                    else if (kind < 18) c = tclr_pkg::CH_TAB;
                    else if (kind < 21) c = tclr_pkg::CH_NUL;
                    else if (kind < 80) c = 8'($urandom_range(126, 32));
                    else c = 8'($urandom);
                    send_char(c, kind >= 88, k == len - 1);
                end
                sent += len;
            end else if (kind < 82) begin
                send_scroll($urandom_range(128) - 64);
                sent++;
            end else if (kind < 97) begin
                send_read();
                sent++;
            end else begin
                send_item(tclr_pkg::MODE_CLEAR, 8'($urandom), 8'($urandom), 1'($urandom),
                          1'($urandom), 8'($urandom), 6'($urandom), 8'($urandom));
                sent++;
            end
        end
    endtask

    initial begin
        for (int i = 0; i < DEPTH; i++) begin
            for (int j = 0; j <= LMAX; j++) begin
                text_lines[i][j] = '0;
                byte_known[i][j] = 1'b0;
            end
            line_mark[i] = 1'b0;
        end
        line_mark[0] = 1'b1;
        top_ix = 0;
        oldest_ix = 0;
        write_ix = 0;
        write_col = 0;
        drop_on = 1'b0;
        cfg_len = int'(tclr_pkg::RST_LINE_LENGTH);
        cfg_ring = int'(tclr_pkg::RST_RING_LINES);
        cfg_height = int'(tclr_pkg::RST_VIEW_HEIGHT);
        cfg_tab = int'(tclr_pkg::RST_TAB_WIDTH);
        cfg_stop = 0;
        cfg_one = 0;
        cfg_en = 1;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        configure(40, 64, 20, 8, 0, 0, 1);
        test_random(200);
        configure(128, 64, 64, 128, 0, 0, 1);
        no_idle = 1'b1;
        test_random(120);
        no_idle = 1'b0;
        configure(8, 2, 0, 1, 0, 0, 1);
        test_random(100);
        configure(5, 6, 3, 3, 1, 0, 1);
        test_random(120);
        configure(16, 10, 4, 4, 0, 1, 1);
        test_random(120);
        configure(0, 1, 100, 0, 1, 1, 1);
        test_random(60);
        configure(200, 127, 7, 255, 0, 0, 1);
        test_random(100);
        configure(12, 8, 8, 5, 0, 0, 0);
        test_random(40);
        configure(12, 8, 8, 5, 0, 0, 1);
        test_random(60);

        drain();
        repeat (50) @(posedge i_clk);
        if (failures == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end
endmodule

// File: text_console_line_ring_top.f
design/tclr_pkg.sv
design/tclr_ram.sv
design/tclr_regs.sv
design/tclr_ctrl.sv
design/tclr_dp.sv
design/text_console_line_ring_top.sv
tb/sv/tb_text_console_line_ring_top.sv
